@@ hdl/metp_pkg.sv @@
`timescale 1ns / 1ps

package metp_pkg;

    // Command codes on the request channel
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Fixed port widths
    localparam int CMD_BITS       = 2;
    localparam int NODE_PORT_BITS = 16;
    localparam int ROW_PORT_BITS  = 10;
    localparam int PAIR_BITS      = 12;

    // Shared edge of a match, in precedence order (later wins)
    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_AB   = 2'd1,
        EDGE_BC   = 2'd2,
        EDGE_CA   = 2'd3
    } edge_t;

endpackage

@@ hdl/metp_match.sv @@
`timescale 1ns / 1ps

// Edge tests of one stored triangle x against each edge of row triangle (a,b,c).
module metp_match #(
    parameter int W = 16
) (
    input  logic [W-1:0]       x0,
    input  logic [W-1:0]       x1,
    input  logic [W-1:0]       x2,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    input  logic [W-1:0]       c,
    output metp_pkg::edge_t    edge_sel,
    output logic [W-1:0]       nbr
);

    // {hit, neighbor}; neighbor of the last matching test
    function automatic logic [W:0] edge_test(
        input logic [W-1:0] y0,
        input logic [W-1:0] y1,
        input logic [W-1:0] y2,
        input logic [W-1:0] p,
        input logic [W-1:0] q,
        input logic [W-1:0] r
    );
        logic         hit;
        logic [W-1:0] n;
        hit = 1'b0;
        n   = '0;
        if (y0 == p && y1 == q && y2 != r)
        begin
            hit = 1'b1; n = y2;
        end
        if (y0 == q && y1 == p && y2 != r)
        begin
            hit = 1'b1; n = y2;
        end
        if (y0 == p && y1 != r && y2 == q)
        begin
            hit = 1'b1; n = y1;
        end
        if (y0 == q && y1 != r && y2 == p)
        begin
            hit = 1'b1; n = y1;
        end
        if (y0 != r && y1 == p && y2 == q)
        begin
            hit = 1'b1; n = y0;
        end
        if (y0 != r && y1 == q && y2 == p)
        begin
            hit = 1'b1; n = y0;
        end
        return {hit, n};
    endfunction

    logic [W:0] t_ab;
    logic [W:0] t_bc;
    logic [W:0] t_ca;

    always_comb
    begin
        t_ab = edge_test(x0, x1, x2, a, b, c);
        t_bc = edge_test(x0, x1, x2, b, c, a);
        t_ca = edge_test(x0, x1, x2, c, a, b);
        if (t_ca[W])
        begin
            edge_sel = metp_pkg::EDGE_CA;
            nbr      = t_ca[W-1:0];
        end
        else if (t_bc[W])
        begin
            edge_sel = metp_pkg::EDGE_BC;
            nbr      = t_bc[W-1:0];
        end
        else if (t_ab[W])
        begin
            edge_sel = metp_pkg::EDGE_AB;
            nbr      = t_ab[W-1:0];
        end
        else
        begin
            edge_sel = metp_pkg::EDGE_NONE;
            nbr      = '0;
        end
    end

endmodule

@@ hdl/mesh_edge_adjacent_triangle_pairs.sv @@
`timescale 1ns / 1ps

// Triangle mesh edge adjacency scanner.
// Request channel (in_valid/in_ready): cmd selects load, scan or clear.
//   Load writes node_a/b/c at the fill count (ignored when full), clear zeroes
//   the fill count and the running pair index; neither gives a result.
//   Scan of row i compares triangle i with stored triangles i..count-1.
// Result channel (out_valid/out_ready): a scan gives one result per pair
//   found (up to MAX_ROW_PAIRS, overflow flags dropped ones), or a single
//   found=0 result when nothing matched; last marks the final one.
// Timing: load and clear complete in S_IDLE. A scan reads the store from the
//   row up to the fill count (one entry per cycle through the single store read
//   port), then passes each result through the pair buffer; a row past the
//   fill count goes straight to its found=0 result. Results are buffered until
//   the scan ends, since overflow and last are only known then.
// in_ready is high only while no scan is in progress; the last result of a
//   scan sits in the output register while the next request is taken.
// A stalled receiver holds the output register; draining pauses behind it.
// Reset clears the fill count, pair index and all handshake state; the
//   triangle store itself is not cleared and is only read below the count.
module mesh_edge_adjacent_triangle_pairs #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int NODE_BITS     = 16,
    parameter int MAX_ROW_PAIRS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [metp_pkg::CMD_BITS-1:0]         cmd,
    input  logic [metp_pkg::NODE_PORT_BITS-1:0]   node_a,
    input  logic [metp_pkg::NODE_PORT_BITS-1:0]   node_b,
    input  logic [metp_pkg::NODE_PORT_BITS-1:0]   node_c,
    input  logic [metp_pkg::ROW_PORT_BITS-1:0]    row_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  found,
    output logic [metp_pkg::PAIR_BITS-1:0]        pair_index,
    output logic [metp_pkg::NODE_PORT_BITS-1:0]   outer_node_first,
    output logic [metp_pkg::NODE_PORT_BITS-1:0]   shared_node_one,
    output logic [metp_pkg::NODE_PORT_BITS-1:0]   shared_node_two,
    output logic [metp_pkg::NODE_PORT_BITS-1:0]   outer_node_second,
    output logic                                  overflow,
    output logic                                  last
);

    localparam int NPW = metp_pkg::NODE_PORT_BITS;
    localparam int PW  = metp_pkg::PAIR_BITS;
    // stored node width: nodes beyond the port width never survive
    localparam int SW  = (NODE_BITS < NPW) ? NODE_BITS : NPW;
    localparam int AW  = $clog2(MAX_TRIANGLES);
    localparam int CW  = $clog2(MAX_TRIANGLES + 1);
    localparam int RW  = (CW > metp_pkg::ROW_PORT_BITS) ? CW : metp_pkg::ROW_PORT_BITS;
    localparam int KW  = $clog2(MAX_ROW_PAIRS + 1);
    localparam int BW  = $clog2(MAX_ROW_PAIRS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,     // row triangle read, issue first compare read
        S_SCAN,    // one stored triangle compared per cycle
        S_RD,      // read pair buffer
        S_LD       // load output register
    } state_t;

    state_t          state_reg,   state_next;
    logic [CW-1:0]   count_reg,   count_next;
    logic [PW-1:0]   pair_reg,    pair_next;
    logic [PW-1:0]   base_reg,    base_next;
    logic [CW-1:0]   j_reg,       j_next;
    logic            dv_reg,      dv_next;
    logic [SW-1:0]   a_reg,       a_next;
    logic [SW-1:0]   b_reg,       b_next;
    logic [SW-1:0]   c_reg,       c_next;
    logic [KW-1:0]   hits_reg,    hits_next;
    logic            over_reg,    over_next;
    logic [KW-1:0]   k_reg,       k_next;

    logic            ov_reg,      ov_next;
    logic            fnd_reg,     fnd_next;
    logic [PW-1:0]   pidx_reg,    pidx_next;
    logic [NPW-1:0]  o1_reg,      o1_next;
    logic [NPW-1:0]  s1_reg,      s1_next;
    logic [NPW-1:0]  s2_reg,      s2_next;
    logic [NPW-1:0]  o2_reg,      o2_next;
    logic            ovf_reg,     ovf_next;
    logic            last_reg,    last_next;

    // triangle store: one write port, one registered read port
    logic [3*SW-1:0] tri_mem [MAX_TRIANGLES];
    logic            st_we;
    logic [AW-1:0]   st_waddr;
    logic            st_re;
    logic [AW-1:0]   st_raddr;
    logic [3*SW-1:0] st_rdata;

    // pair buffer: {edge, neighbor} per accepted match
    logic [SW+1:0]   rb_mem [MAX_ROW_PAIRS];
    logic            rb_we;
    logic [BW-1:0]   rb_waddr;
    logic            rb_re;
    logic [SW+1:0]   rb_rdata;

    logic            in_acc;
    logic [RW-1:0]   row_ext;
    logic            row_ok;
    logic            more;
    logic            out_free;
    logic            match_hit;

    metp_pkg::edge_t m_edge;
    logic [SW-1:0]   m_nbr;
    metp_pkg::edge_t rb_edge;
    logic [SW-1:0]   rb_nbr;

    metp_match #(
        .W (SW)
    ) u_match (
        .x0       (st_rdata[3*SW-1:2*SW]),
        .x1       (st_rdata[2*SW-1:SW]),
        .x2       (st_rdata[SW-1:0]),
        .a        (a_reg),
        .b        (b_reg),
        .c        (c_reg),
        .edge_sel (m_edge),
        .nbr      (m_nbr)
    );

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            tri_mem[st_waddr] <= {node_a[SW-1:0], node_b[SW-1:0], node_c[SW-1:0]};
        end
        if (st_re)
        begin
            st_rdata <= tri_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rb_we)
        begin
            rb_mem[rb_waddr] <= {m_edge, m_nbr};
        end
        if (rb_re)
        begin
            rb_rdata <= rb_mem[k_reg[BW-1:0]];
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign row_ext   = RW'(row_index);
    assign row_ok    = row_ext < RW'(count_reg);
    assign more      = j_reg < count_reg;
    assign out_free  = !ov_reg || out_ready;
    assign match_hit = dv_reg && (m_edge != metp_pkg::EDGE_NONE);
    assign rb_edge   = metp_pkg::edge_t'(rb_rdata[SW+1:SW]);
    assign rb_nbr    = rb_rdata[SW-1:0];

    assign st_we     = in_acc && (cmd == metp_pkg::CMD_LOAD)
                       && (count_reg < CW'(MAX_TRIANGLES));
    assign st_waddr  = count_reg[AW-1:0];
    assign rb_we     = (state_reg == S_SCAN) && match_hit
                       && (hits_reg < KW'(MAX_ROW_PAIRS));
    assign rb_waddr  = hits_reg[BW-1:0];
    assign rb_re     = (state_reg == S_RD);

    always_comb
    begin
        st_re    = 1'b0;
        st_raddr = j_reg[AW-1:0];
        if (state_reg == S_IDLE)
        begin
            st_re    = in_acc && (cmd == metp_pkg::CMD_SCAN) && row_ok;
            st_raddr = row_ext[AW-1:0];
        end
        else if (state_reg == S_ROW)
        begin
            st_re = 1'b1;
        end
        else if (state_reg == S_SCAN)
        begin
            st_re = more;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        base_next  = base_reg;
        j_next     = j_reg;
        dv_next    = dv_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        hits_next  = hits_reg;
        over_next  = over_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !out_ready;
        fnd_next   = fnd_reg;
        pidx_next  = pidx_reg;
        o1_next    = o1_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        o2_next    = o2_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd)
                        metp_pkg::CMD_LOAD:
                        begin
                            if (st_we)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        metp_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            pair_next  = '0;
                        end
                        metp_pkg::CMD_SCAN:
                        begin
                            base_next = pair_reg;
                            hits_next = '0;
                            over_next = 1'b0;
                            k_next    = '0;
                            j_next    = row_ext[CW-1:0];
                            state_next = row_ok ? S_ROW : S_LD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ROW:
            begin
                // store data is the row triangle; compares start at j = row
                a_next     = st_rdata[3*SW-1:2*SW];
                b_next     = st_rdata[2*SW-1:SW];
                c_next     = st_rdata[SW-1:0];
                j_next     = j_reg + CW'(1);
                dv_next    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (match_hit)
                begin
                    if (rb_we)
                    begin
                        hits_next = hits_reg + KW'(1);
                        pair_next = pair_reg + PW'(1);
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
                dv_next = more;
                if (more)
                begin
                    j_next = j_reg + CW'(1);
                end
                else if (!dv_reg)
                begin
                    state_next = (hits_reg != '0) ? S_RD : S_LD;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (hits_reg == '0)
                    begin
                        fnd_next   = 1'b0;
                        pidx_next  = '0;
                        o1_next    = '0;
                        s1_next    = '0;
                        s2_next    = '0;
                        o2_next    = '0;
                        ovf_next   = 1'b0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fnd_next  = 1'b1;
                        pidx_next = base_reg + PW'(k_reg);
                        o2_next   = NPW'(rb_nbr);
                        ovf_next  = over_reg;
                        case (rb_edge)
                            metp_pkg::EDGE_AB:
                            begin
                                o1_next = NPW'(c_reg);
                                s1_next = NPW'(a_reg);
                                s2_next = NPW'(b_reg);
                            end
                            metp_pkg::EDGE_BC:
                            begin
                                o1_next = NPW'(a_reg);
                                s1_next = NPW'(c_reg);
                                s2_next = NPW'(b_reg);
                            end
                            default:
                            begin
                                o1_next = NPW'(b_reg);
                                s1_next = NPW'(c_reg);
                                s2_next = NPW'(a_reg);
                            end
                        endcase
                        k_next = k_reg + KW'(1);
                        if (KW'(k_reg + KW'(1)) == hits_reg)
                        begin
                            last_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            last_next  = 1'b0;
                            state_next = S_RD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pair_reg  <= '0;
            base_reg  <= '0;
            j_reg     <= '0;
            dv_reg    <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            hits_reg  <= '0;
            over_reg  <= 1'b0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            fnd_reg   <= 1'b0;
            pidx_reg  <= '0;
            o1_reg    <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
            o2_reg    <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pair_reg  <= pair_next;
            base_reg  <= base_next;
            j_reg     <= j_next;
            dv_reg    <= dv_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            hits_reg  <= hits_next;
            over_reg  <= over_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            fnd_reg   <= fnd_next;
            pidx_reg  <= pidx_next;
            o1_reg    <= o1_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            o2_reg    <= o2_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid         = ov_reg;
    assign found             = fnd_reg;
    assign pair_index        = pidx_reg;
    assign outer_node_first  = o1_reg;
    assign shared_node_one   = s1_reg;
    assign shared_node_two   = s2_reg;
    assign outer_node_second = o2_reg;
    assign overflow          = ovf_reg;
    assign last              = last_reg;

endmodule

@@ hdl/metp_checker.sv @@
`timescale 1ns / 1ps

module metp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic [metp_pkg::CMD_BITS-1:0]         cmd,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   node_a,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   node_b,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   node_c,
    input logic [metp_pkg::ROW_PORT_BITS-1:0]    row_index,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  found,
    input logic [metp_pkg::PAIR_BITS-1:0]        pair_index,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   outer_node_first,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   shared_node_one,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   shared_node_two,
    input logic [metp_pkg::NODE_PORT_BITS-1:0]   outer_node_second,
    input logic                                  overflow,
    input logic                                  last
);

    localparam int PB = metp_pkg::PAIR_BITS;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pair_index)
            && $stable(found) && $stable(last) && $stable(outer_node_second))
        else $error("result changed while stalled");

    // empty-row result has zero index, outer nodes and overflow, and closes the scan
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && !overflow && pair_index == '0
            && outer_node_first == '0 && outer_node_second == '0)
        else $error("malformed no-match result");

    // no new request while a scan still has results to drain
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("request taken mid-scan");

    // consecutive results of one scan carry consecutive pair indexes
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            !out_valid || (pair_index == $past(pair_index) + PB'(1)))
        else $error("pair index not consecutive");

endmodule

bind mesh_edge_adjacent_triangle_pairs metp_checker u_metp_checker (.*);
